// ===== rtl/wsdf_pkg.sv =====
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsdf_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_CLOSED
  } phase_e;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_BYTES_M1 = 3'd1;
  localparam logic [2:0] EXT64_BYTES_M1 = 3'd7;
  localparam logic [2:0] KEY_BYTES_M1   = 3'd3;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser, one byte per cycle
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o carry one received byte (rx_byte_i)
// per item. output channel: out_valid_o / out_ready_i carry one result item
// with the unmasked payload byte, its frame kind and the end flags.
// header bytes give no result, except the byte that completes the header of
// a frame with empty payload, which gives one item with data_valid_o low and
// frame_end_o high.
// a result is registered and presented in the cycle after its byte is taken.
// throughput: one byte per cycle, set by the single parse step between the
// byte and the result register; a new byte is taken whenever the result
// register is empty or being drained in the same cycle.
// when the receiver stalls, in_ready_o drops until the held result is taken.
// reset clears the parser to expect a first header byte and empties the
// result register. once a close frame ends, bytes are still taken but give
// no result and change nothing until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_byte_o,
  output logic       data_valid_o,
  output logic [1:0] frame_kind_o,
  output logic       frame_end_o,
  output logic       message_end_o,
  output logic       message_binary_o
);
  import wsdf_pkg::*;

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        mask_q, mask_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic [3:0]  msg_op_q, msg_op_d;

  logic        out_valid_q;
  logic [7:0]  data_byte_q;
  logic        data_valid_q;
  logic [1:0]  kind_q;
  logic        fend_q;
  logic        mend_q;
  logic        bin_q;

  logic        in_fire;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_valid;
  logic        emit_fend;
  logic [1:0]  kind;
  logic        mend;
  logic        bin;
  logic [7:0]  key_byte;
  logic [6:0]  len;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign len        = rx_byte_i[6:0];

  always_comb begin
    case (opcode_q)
      OP_PING:  kind = KIND_PING;
      OP_CLOSE: kind = KIND_CLOSE;
      default:  kind = KIND_DATA;
    endcase
  end

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    fin_d      = fin_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    key_d      = key_q;
    idx_d      = idx_q;
    msg_op_d   = msg_op_q;
    emit       = 1'b0;
    emit_byte  = 8'h00;
    emit_valid = 1'b0;
    emit_fend  = 1'b0;

    case (phase_q)
      PH_HDR0: begin
        fin_d    = rx_byte_i[7];
        opcode_d = rx_byte_i[3:0];
        if (!(rx_byte_i[3:0] inside {OP_CONT, OP_PING, OP_CLOSE})) begin
          msg_op_d = rx_byte_i[3:0];
        end
        phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        mask_d = rx_byte_i[7];
        key_d  = '0;
        rem_d  = '0;
        if (len == LEN_EXT16) begin
          cnt_d   = EXT16_BYTES_M1;
          phase_d = PH_EXTLEN;
        end else if (len == LEN_EXT64) begin
          cnt_d   = EXT64_BYTES_M1;
          phase_d = PH_EXTLEN;
        end else begin
          rem_d = {57'd0, len};
          if (rx_byte_i[7]) begin
            cnt_d   = KEY_BYTES_M1;
            phase_d = PH_MASK;
          end else begin
            idx_d = '0;
            if (len == '0) begin
              emit      = 1'b1;
              emit_fend = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end
      end
      PH_EXTLEN: begin
        rem_d = {rem_q[55:0], rx_byte_i};
        if (cnt_q == '0) begin
          if (mask_q) begin
            cnt_d   = KEY_BYTES_M1;
            phase_d = PH_MASK;
          end else begin
            idx_d = '0;
            if (rem_d == '0) begin
              emit      = 1'b1;
              emit_fend = 1'b1;
            end else begin
              phase_d = PH_PAYLOAD;
            end
          end
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], rx_byte_i};
        if (cnt_q == '0) begin
          idx_d = '0;
          if (rem_q == '0) begin
            emit      = 1'b1;
            emit_fend = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        idx_d      = idx_q + 2'd1;
        rem_d      = rem_q - 64'd1;
        emit       = 1'b1;
        emit_byte  = rx_byte_i ^ key_byte;
        emit_valid = 1'b1;
        emit_fend  = (rem_q == 64'd1);
      end
      PH_CLOSED: begin
        phase_d = PH_CLOSED;
      end
      default: begin
        phase_d = PH_HDR0;
      end
    endcase

    mend = emit && emit_fend && (kind == KIND_DATA) && fin_q;
    bin  = mend && (msg_op_q == OP_BINARY);

    if (emit && emit_fend) begin
      if (mend) begin
        msg_op_d = OP_CONT;
      end
      if (kind == KIND_CLOSE) begin
        phase_d = PH_CLOSED;
      end else begin
        phase_d = PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      fin_q    <= 1'b0;
      opcode_q <= OP_CONT;
      mask_q   <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      msg_op_q <= OP_CONT;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      fin_q    <= fin_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      msg_op_q <= msg_op_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      data_byte_q  <= emit_byte;
      data_valid_q <= emit_valid;
      kind_q       <= kind;
      fend_q       <= emit_fend;
      mend_q       <= mend;
      bin_q        <= bin;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign data_byte_o      = data_byte_q;
  assign data_valid_o     = data_valid_q;
  assign frame_kind_o     = kind_q;
  assign frame_end_o      = fend_q;
  assign message_end_o    = mend_q;
  assign message_binary_o = bin_q;

  a_mend_on_data_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_end_o |-> frame_end_o && (frame_kind_o == KIND_DATA))
    else $error("message end without data frame end");

  a_binary_only_at_mend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && message_binary_o |-> message_end_o)
    else $error("binary flag outside message end");

  a_empty_item_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !data_valid_o |-> frame_end_o && (data_byte_o == 8'h00))
    else $error("item without data must be an empty frame end");

  a_closed_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED) && !(in_fire && emit))
    else $error("parser left closed state");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the websocket frame deframer
// ----------------------------------------------------------------------------
// feeds the deframer a byte stream of websocket frames built here. The stream
// opens with a directed set of frames: empty payloads, masked and unmasked
// keys, each length encoding, fragmented messages with pings between the
// fragments, messages made only of continuation frames, pong and reserved
// opcodes, and a long ping with fin clear. Random messages with random
// content and malformed noise frames follow. A close frame ends the stream,
// and the bytes sent after it must give no result.
// A scoreboard class tracks the parser state for each byte taken and queues
// the result it expects. Each result taken is checked field by field against
// the oldest queued result. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import wsdf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RANDOM_BYTES = 1500;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_RSVD_3 = 4'h3;
  localparam logic [3:0] OP_PONG   = 4'hA;
  localparam logic [3:0] OP_RSVD_F = 4'hF;

  localparam int unsigned ENC_7  = 0;
  localparam int unsigned ENC_16 = 1;
  localparam int unsigned ENC_64 = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic [1:0] frame_kind;
    logic       frame_end;
    logic       message_end;
    logic       message_binary;
  } deframe_result_t;

  class deframer_scoreboard;
    phase_e      rx_phase;
    logic        hdr_fin;
    logic [3:0]  hdr_opcode;
    logic        hdr_masked;
    logic [2:0]  field_left;
    logic [63:0] payload_left;
    logic [31:0] key_word;
    logic [1:0]  key_pos;
    logic [3:0]  msg_type_op;
    logic        stream_closed;

    deframe_result_t pending_results[$];
    int unsigned errors;
    int unsigned results_checked;
    int unsigned frames_done;
    int unsigned messages_done;

    function new();
      rx_phase      = PH_HDR0;
      hdr_fin       = 1'b0;
      hdr_opcode    = OP_CONT;
      hdr_masked    = 1'b0;
      field_left    = '0;
      payload_left  = '0;
      key_word      = '0;
      key_pos       = '0;
      msg_type_op   = OP_CONT;
      stream_closed = 1'b0;
      errors          = 0;
      results_checked = 0;
      frames_done     = 0;
      messages_done   = 0;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function void add_result(logic [7:0] data, logic valid, logic fend);
      logic [1:0]      kind;
      logic            mend;
      deframe_result_t r;
      if (hdr_opcode == OP_PING) kind = KIND_PING;
      else if (hdr_opcode == OP_CLOSE) kind = KIND_CLOSE;
      else kind = KIND_DATA;
      mend = fend && (kind == KIND_DATA) && hdr_fin;
      r.data_byte      = data;
      r.data_valid     = valid;
      r.frame_kind     = kind;
      r.frame_end      = fend;
      r.message_end    = mend;
      r.message_binary = mend && (msg_type_op == OP_BINARY);
      pending_results.insert(pending_results.size(), r);
      if (fend) begin
        frames_done++;
        if (mend) begin
          msg_type_op = OP_CONT;
          messages_done++;
        end
        if (kind == KIND_CLOSE) begin
          stream_closed = 1'b1;
          rx_phase      = PH_CLOSED;
        end else begin
          rx_phase = PH_HDR0;
        end
      end
    endfunction

    function void header_complete();
      key_pos = '0;
      if (payload_left == 64'd0) add_result(8'h00, 1'b0, 1'b1);
      else rx_phase = PH_PAYLOAD;
    endfunction

    function void length_complete();
      if (hdr_masked) begin
        field_left = KEY_BYTES_M1;
        rx_phase   = PH_MASK;
      end else begin
        header_complete();
      end
    endfunction

    function void note_rx_byte(logic [7:0] b);
      logic [7:0] key_byte;
      if (stream_closed) return;
      case (rx_phase)
        PH_HDR0: begin
          hdr_fin    = b[7];
          hdr_opcode = b[3:0];
          if (hdr_opcode != OP_CONT && hdr_opcode != OP_PING && hdr_opcode != OP_CLOSE)
            msg_type_op = hdr_opcode;
          rx_phase = PH_HDR1;
        end
        PH_HDR1: begin
          hdr_masked   = b[7];
          key_word     = '0;
          payload_left = '0;
          if (b[6:0] == LEN_EXT16) begin
            field_left = EXT16_BYTES_M1;
            rx_phase   = PH_EXTLEN;
          end else if (b[6:0] == LEN_EXT64) begin
            field_left = EXT64_BYTES_M1;
            rx_phase   = PH_EXTLEN;
          end else begin
            payload_left = {57'd0, b[6:0]};
            length_complete();
          end
        end
        PH_EXTLEN: begin
          payload_left = {payload_left[55:0], b};
          if (field_left == 3'd0) length_complete();
          else field_left = field_left - 3'd1;
        end
        PH_MASK: begin
          key_word = {key_word[23:0], b};
          if (field_left == 3'd0) header_complete();
          else field_left = field_left - 3'd1;
        end
        PH_PAYLOAD: begin
          key_byte     = key_word[8 * (3 - key_pos) +: 8];
          key_pos      = key_pos + 2'd1;
          payload_left = payload_left - 64'd1;
          add_result(b ^ key_byte, 1'b1, payload_left == 64'd0);
        end
        default: begin
          rx_phase = PH_HDR0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, actual %h", $time, got);
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("data_valid", want.data_valid, got.data_valid);
      compare_field("frame_kind", want.frame_kind, got.frame_kind);
      compare_field("frame_end", want.frame_end, got.frame_end);
      compare_field("message_end", want.message_end, got.message_end);
      compare_field("message_binary", want.message_binary, got.message_binary);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] data_byte;
  logic       data_valid;
  logic [1:0] frame_kind;
  logic       frame_end;
  logic       message_end;
  logic       message_binary;

  deframer_scoreboard sb;
  bit          tx_gap_mode;
  bit          rx_stall_mode;
  int unsigned rx_stall_left = 0;
  int unsigned bytes_sent;
  int unsigned cycle_count = 0;

  websocket_frame_deframer dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .rx_byte_i        (rx_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .data_byte_o      (data_byte),
    .data_valid_o     (data_valid),
    .frame_kind_o     (frame_kind),
    .frame_end_o      (frame_end),
    .message_end_o    (message_end),
    .message_binary_o (message_binary)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver with random stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result({data_byte, data_valid, frame_kind, frame_end, message_end,
                         message_binary});
      if (!rx_stall_mode) begin
        out_ready <= 1'b1;
      end else if (rx_stall_left != 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:14]:  begin rx_stall_left = $urandom_range(0, 2);  out_ready <= 1'b0; end
          [15:17]: begin rx_stall_left = $urandom_range(8, 40); out_ready <= 1'b0; end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    if (tx_gap_mode) begin
      r = $urandom_range(0, 99);
      if (r < 20) gap = $urandom_range(1, 3);
      else if (r < 23) gap = $urandom_range(4, 30);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  function automatic logic [7:0] payload_byte();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  task automatic send_frame(input logic fin, input logic [3:0] opcode, input logic masked,
                            input int unsigned len, input int unsigned enc);
    logic [31:0] key;
    logic [63:0] len64;
    logic [2:0]  rsv;
    key   = $urandom;
    rsv   = 3'($urandom);
    len64 = 64'(len);
    send_byte({fin, rsv, opcode});
    case (enc)
      ENC_7: begin
        send_byte({masked, len64[6:0]});
      end
      ENC_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int unsigned i = 0; i < len; i++) send_byte(payload_byte());
  endtask

  task automatic pick_length(output int unsigned len, output int unsigned enc);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) len = $urandom_range(0, 15);
    else if (r < 88) len = $urandom_range(16, 125);
    else len = $urandom_range(126, 400);
    r = $urandom_range(0, 9);
    if (len > 125) enc = (r < 8) ? ENC_16 : ENC_64;
    else enc = (r < 7) ? ENC_7 : ((r < 9) ? ENC_16 : ENC_64);
  endtask

  task automatic send_random_message();
    int unsigned parts;
    int unsigned len;
    int unsigned enc;
    int unsigned r;
    logic [3:0]  first_op;
    parts = $urandom_range(1, 4);
    r = $urandom_range(0, 9);
    if (r < 4) begin
      first_op = OP_TEXT;
    end else if (r < 8) begin
      first_op = OP_BINARY;
    end else begin
      do first_op = 4'($urandom_range(3, 15));
      while (first_op == OP_CLOSE || first_op == OP_PING);
    end
    for (int unsigned p = 0; p < parts; p++) begin
      if ($urandom_range(0, 4) == 0) begin
        pick_length(len, enc);
        send_frame($urandom_range(0, 7) != 0, OP_PING, 1'($urandom), len, enc);
      end
      pick_length(len, enc);
      send_frame(p == parts - 1, (p == 0) ? first_op : OP_CONT, 1'($urandom), len, enc);
    end
  endtask

  initial begin
    int unsigned random_target;
    int unsigned len;
    int unsigned enc;
    logic [3:0]  op;
    bit          paused;

    sb = new();
    tx_gap_mode   = 1'b0;
    rx_stall_mode = 1'b0;
    bytes_sent    = 0;
    paused        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames
    send_frame(1'b1, OP_TEXT, 1'b0, 0, ENC_7);
    send_frame(1'b1, OP_BINARY, 1'b1, 5, ENC_7);
    send_frame(1'b0, OP_BINARY, 1'b1, 3, ENC_7);
    send_frame(1'b1, OP_PING, 1'b1, 2, ENC_7);
    send_frame(1'b0, OP_CONT, 1'b0, 0, ENC_7);
    send_frame(1'b1, OP_CONT, 1'b1, 4, ENC_7);
    send_frame(1'b1, OP_CONT, 1'b0, 3, ENC_7);
    send_frame(1'b1, OP_PONG, 1'b1, 2, ENC_7);
    send_frame(1'b1, OP_RSVD_3, 1'b0, 1, ENC_7);
    send_frame(1'b1, OP_RSVD_F, 1'b1, 1, ENC_7);
    tx_gap_mode   = 1'b1;
    rx_stall_mode = 1'b1;
    send_frame(1'b0, OP_BINARY, 1'b0, 2, ENC_7);
    send_frame(1'b1, OP_TEXT, 1'b1, 2, ENC_7);
    send_frame(1'b1, OP_BINARY, 1'b1, 125, ENC_7);
    send_frame(1'b1, OP_BINARY, 1'b0, 126, ENC_16);
    send_frame(1'b0, OP_TEXT, 1'b1, 5, ENC_16);
    send_frame(1'b1, OP_CONT, 1'b0, 3, ENC_64);
    send_frame(1'b1, OP_BINARY, 1'b1, 0, ENC_64);
    send_frame(1'b0, OP_PING, 1'b0, 130, ENC_16);
    send_frame(1'b1, OP_PING, 1'b1, 0, ENC_7);

    // random messages with some malformed frames mixed in
    random_target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < random_target) begin
      if ($urandom_range(0, 5) == 0) begin
        tx_gap_mode   = $urandom_range(0, 3) != 0;
        rx_stall_mode = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 4) == 0) begin
        do op = 4'($urandom); while (op == OP_CLOSE);
        pick_length(len, enc);
        send_frame(1'($urandom), op, 1'($urandom), len, enc);
      end else begin
        send_random_message();
      end
      if (!paused && bytes_sent > random_target - RANDOM_BYTES / 2) begin
        paused = 1'b1;
        wait_results_done();
      end
    end

    // close ends the stream, later bytes must be ignored
    send_frame(1'b1, OP_CLOSE, 1'b1, 4, ENC_7);
    repeat (16) send_byte(8'($urandom));

    wait_results_done();
    repeat (10) @(posedge clk);
    $display("sent %0d bytes, checked %0d result items", bytes_sent, sb.results_checked);
    $display("%0d frames and %0d messages completed", sb.frames_done, sb.messages_done);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wsdf_pkg.sv
rtl/websocket_frame_deframer.sv
tb/sv/tb_top.sv
